[sv/address_range_claim_table_core_macros.svh]
// ----------------------------------------------------------------------------
// address range claim table - assertion macros
// shared concurrent assertion forms for the claim table rtl
// ----------------------------------------------------------------------------
`ifndef ADDRESS_RANGE_CLAIM_TABLE_CORE_MACROS_SVH
`define ADDRESS_RANGE_CLAIM_TABLE_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define ARCT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ARCT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/arct_pkg.sv]
// ----------------------------------------------------------------------------
// arct_pkg
// types, codes and constants of the address range claim table
// ----------------------------------------------------------------------------
`default_nettype none

package arct_pkg;

    localparam int ARCT_MAX_CLAIMS = 64;

    localparam logic [2:0] CMD_INSTALL   = 3'd0;
    localparam logic [2:0] CMD_REM_HND   = 3'd1;
    localparam logic [2:0] CMD_REM_OWNER = 3'd2;
    localparam logic [2:0] CMD_FIND      = 3'd3;
    localparam logic [2:0] CMD_CLR_COLL  = 3'd4;

    localparam logic [3:0] ST_INSTALLED   = 4'd0;
    localparam logic [3:0] ST_EXISTING    = 4'd1;
    localparam logic [3:0] ST_TARGET_ZERO = 4'd2;
    localparam logic [3:0] ST_DETOUR_ZERO = 4'd3;
    localparam logic [3:0] ST_OVERLAP     = 4'd4;
    localparam logic [3:0] ST_BACKEND     = 4'd5;
    localparam logic [3:0] ST_FULL        = 4'd6;
    localparam logic [3:0] ST_REMOVED     = 4'd7;
    localparam logic [3:0] ST_NOT_FOUND   = 4'd8;
    localparam logic [3:0] ST_COVERED     = 4'd9;
    localparam logic [3:0] ST_NOT_COVERED = 4'd10;

    localparam logic [4:0] MIN_LEN_RESET = 5'd5;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] owner_id;
        logic [63:0] target_addr;
        logic [63:0] detour_id;
        logic [4:0]  measured_len;
        logic [2:0]  patch_error;
        logic [31:0] handle;
        logic [63:0] query_addr;
    } t_req;

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] handle_out;
        logic [6:0]  removed_count;
        logic [15:0] hit_owner;
        logic [63:0] hit_target;
        logic [4:0]  hit_len;
        logic [15:0] collision_count;
    } t_rsp;

    typedef struct packed {
        logic        valid;
        logic [63:0] start;
        logic [4:0]  len;
        logic [15:0] owner;
        logic [63:0] detour;
        logic [31:0] handle;
    } t_entry;

    typedef struct packed {
        logic exact;
        logic overlap;
        logic owner_eq;
        logic handle_eq;
        logic covers;
    } t_cmp;

endpackage

`default_nettype wire

[sv/arct_mem.sv]
// ----------------------------------------------------------------------------
// arct_mem
// claim entry store, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module arct_mem #(
    parameter int MAX_CLAIMS = arct_pkg::ARCT_MAX_CLAIMS
) (
    input  wire                            i_clk,
    input  wire                            i_we,
    input  wire [$clog2(MAX_CLAIMS)-1:0]   i_waddr,
    input  wire arct_pkg::t_entry          i_wdata,
    input  wire                            i_re,
    input  wire [$clog2(MAX_CLAIMS)-1:0]   i_raddr,
    output arct_pkg::t_entry               o_rdata
);
    import arct_pkg::*;

    t_entry r_mem [MAX_CLAIMS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[sv/arct_cmp.sv]
// ----------------------------------------------------------------------------
// arct_cmp
// match, overlap and cover tests of one request against one entry
// ----------------------------------------------------------------------------
`default_nettype none

module arct_cmp (
    input  wire arct_pkg::t_req   i_req,
    input  wire [4:0]             i_len,
    input  wire arct_pkg::t_entry i_ent,
    output arct_pkg::t_cmp        o_cmp
);
    import arct_pkg::*;

    logic [64:0] d_ts;
    logic [64:0] d_st;
    logic [64:0] d_qs;
    logic        ovl;

    assign d_ts = {1'b0, i_req.target_addr} - {1'b0, i_ent.start};
    assign d_st = {1'b0, i_ent.start} - {1'b0, i_req.target_addr};
    assign d_qs = {1'b0, i_req.query_addr} - {1'b0, i_ent.start};

    always_comb begin
        if (!d_ts[64]) begin
            ovl = (d_ts[63:5] == '0) && (d_ts[4:0] < i_ent.len);
        end else begin
            ovl = (d_st[63:5] == '0) && (d_st[4:0] < i_len);
        end
    end

    assign o_cmp.exact     = i_ent.valid && (i_ent.start == i_req.target_addr)
                             && (i_ent.owner == i_req.owner_id)
                             && (i_ent.detour == i_req.detour_id);
    assign o_cmp.overlap   = i_ent.valid && ovl;
    assign o_cmp.owner_eq  = i_ent.valid && (i_ent.owner == i_req.owner_id);
    assign o_cmp.handle_eq = i_ent.valid && (i_req.handle != '0)
                             && (i_ent.handle == i_req.handle);
    assign o_cmp.covers    = i_ent.valid && !d_qs[64] && (d_qs[63:5] == '0)
                             && (d_qs[4:0] < i_ent.len);

endmodule

`default_nettype wire

[sv/address_range_claim_table_core.sv]
// a request is taken only in idle; the entry store is swept through its single
// read port one entry per cycle for every command, and the result is registered
// once the sweep ends and the output is free; no new request is taken before then
// reset: a clearing pass invalidates every entry, and no request is taken
// until it ends; next handle 1, collision count 0
// ----------------------------------------------------------------------------
// address_range_claim_table_core
// bounded table of claimed address ranges with install, remove and lookup
// ----------------------------------------------------------------------------
`default_nettype none

module address_range_claim_table_core #(
    parameter int MAX_CLAIMS = arct_pkg::ARCT_MAX_CLAIMS
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [4:0]           i_cfg_wdata,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire arct_pkg::t_req i_req,
    output logic                o_valid,
    input  wire                 i_stall,
    output arct_pkg::t_rsp      o_rsp
);
    import arct_pkg::*;
    `include "address_range_claim_table_core_macros.svh"

    localparam int IDX_W = $clog2(MAX_CLAIMS);
    localparam int CNT_W = $clog2(MAX_CLAIMS + 1);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(MAX_CLAIMS - 1);

    localparam logic [1:0] S_CLR  = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]       r_state;
    logic [CNT_W-1:0] r_idx;
    logic             r_pv;
    logic [IDX_W-1:0] r_pidx;
    t_req             r_req;
    logic [4:0]       r_len;
    logic [4:0]       r_min_len;
    logic [31:0]      r_nh;
    logic [15:0]      r_coll;
    logic             r_exact;
    logic [31:0]      r_exact_h;
    logic             r_ovl;
    logic             r_free_ok;
    logic [IDX_W-1:0] r_free;
    logic             r_found;
    t_entry           r_hit;
    logic [6:0]       r_rm_cnt;
    logic             r_ovalid;
    t_rsp             r_rsp;

    t_rsp             n_rsp;
    logic [15:0]      n_coll;
    logic [31:0]      n_nh;
    logic             ins_ok;
    logic             fin_go;
    logic             accept;
    logic             rd_en;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    t_entry           mem_wdata;
    t_entry           rdata;
    t_cmp             cm;
    logic             rm_h;
    logic             rm_o;

    assign accept = i_valid && (r_state == S_IDLE);
    assign o_stall = (r_state != S_IDLE);
    assign rd_en = (r_state == S_SCAN) && (r_idx < CNT_W'(MAX_CLAIMS));
    assign fin_go = (r_state == S_FIN) && (!r_ovalid || !i_stall);

    arct_mem #(.MAX_CLAIMS(MAX_CLAIMS)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (rd_en),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (rdata)
    );

    arct_cmp u_cmp (
        .i_req (r_req),
        .i_len (r_len),
        .i_ent (rdata),
        .o_cmp (cm)
    );

    assign rm_h = (r_state == S_SCAN) && r_pv && (r_req.cmd == CMD_REM_HND)
                  && cm.handle_eq && !r_found;
    assign rm_o = (r_state == S_SCAN) && r_pv && (r_req.cmd == CMD_REM_OWNER)
                  && cm.owner_eq;

    always_comb begin
        n_rsp  = '0;
        n_coll = r_coll;
        n_nh   = r_nh;
        ins_ok = 1'b0;
        n_rsp.status = ST_NOT_FOUND;
        case (r_req.cmd)
            CMD_INSTALL: begin
                if (r_req.target_addr == '0) begin
                    n_rsp.status = ST_TARGET_ZERO;
                end else if (r_req.detour_id == '0) begin
                    n_rsp.status = ST_DETOUR_ZERO;
                end else if (r_exact) begin
                    n_rsp.status = ST_EXISTING;
                    n_rsp.handle_out = r_exact_h;
                end else if (r_ovl) begin
                    n_rsp.status = ST_OVERLAP;
                    if (r_coll != 16'hFFFF) begin
                        n_coll = r_coll + 16'd1;
                    end
                end else if (r_req.patch_error != '0) begin
                    n_rsp.status = ST_BACKEND;
                end else if (!r_free_ok) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    n_rsp.status = ST_INSTALLED;
                    n_rsp.handle_out = r_nh;
                    ins_ok = 1'b1;
                    n_nh = (r_nh == 32'hFFFF_FFFF) ? 32'd1 : r_nh + 32'd1;
                end
            end
            CMD_REM_HND: begin
                if (r_found) begin
                    n_rsp.status = ST_REMOVED;
                    n_rsp.handle_out = r_req.handle;
                end
            end
            CMD_REM_OWNER: begin
                n_rsp.removed_count = r_rm_cnt;
                if (r_rm_cnt != '0) begin
                    n_rsp.status = ST_REMOVED;
                end
            end
            CMD_FIND: begin
                if (r_found) begin
                    n_rsp.status = ST_COVERED;
                    n_rsp.handle_out = r_hit.handle;
                    n_rsp.hit_owner = r_hit.owner;
                    n_rsp.hit_target = r_hit.start;
                    n_rsp.hit_len = r_hit.len;
                end else begin
                    n_rsp.status = ST_NOT_COVERED;
                end
            end
            CMD_CLR_COLL: begin
                n_coll = '0;
                n_rsp.status = ST_REMOVED;
            end
            default: begin
                n_rsp.status = ST_NOT_FOUND;
            end
        endcase
        n_rsp.collision_count = n_coll;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_pidx;
        mem_wdata = '0;
        case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[IDX_W-1:0];
            end
            S_SCAN: begin
                mem_we = rm_h || rm_o;
            end
            S_FIN: begin
                mem_we    = fin_go && ins_ok;
                mem_waddr = r_free;
                mem_wdata.valid  = 1'b1;
                mem_wdata.start  = r_req.target_addr;
                mem_wdata.len    = r_len;
                mem_wdata.owner  = r_req.owner_id;
                mem_wdata.detour = r_req.detour_id;
                mem_wdata.handle = r_nh;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= MIN_LEN_RESET;
        end else if (i_cfg_we) begin
            r_min_len <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_idx    <= '0;
            r_pv     <= 1'b0;
            r_nh     <= 32'd1;
            r_coll   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (fin_go) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            r_pv <= rd_en;
            case (r_state)
                S_CLR: begin
                    if (r_idx[IDX_W-1:0] == LAST) begin
                        r_idx   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_idx   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (rd_en) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                    if (r_pv && (r_pidx == LAST)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (fin_go) begin
                        r_coll   <= n_coll;
                        r_nh     <= n_nh;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= r_idx[IDX_W-1:0];
        if (fin_go) begin
            r_rsp <= n_rsp;
        end
        if (accept) begin
            r_req     <= i_req;
            r_len     <= (i_req.measured_len != '0) ? i_req.measured_len :
                         (r_min_len != '0) ? r_min_len : 5'd1;
            r_exact   <= 1'b0;
            r_ovl     <= 1'b0;
            r_free_ok <= 1'b0;
            r_found   <= 1'b0;
            r_rm_cnt  <= '0;
        end else if ((r_state == S_SCAN) && r_pv) begin
            if (cm.exact && !r_exact) begin
                r_exact   <= 1'b1;
                r_exact_h <= rdata.handle;
            end
            if (cm.overlap) begin
                r_ovl <= 1'b1;
            end
            if (!rdata.valid && !r_free_ok) begin
                r_free_ok <= 1'b1;
                r_free    <= r_pidx;
            end
            if (rm_h) begin
                r_found <= 1'b1;
            end
            if ((r_req.cmd == CMD_FIND) && cm.covers && !r_found) begin
                r_found <= 1'b1;
                r_hit   <= rdata;
            end
            if (rm_o && (r_rm_cnt != 7'h7F)) begin
                r_rm_cnt <= r_rm_cnt + 7'd1;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_rsp   = r_rsp;

    `ARCT_ASSERT_IMP(a_scan_wr_remove, i_clk, i_rst_n, (r_state == S_SCAN) && mem_we,
        (r_req.cmd == CMD_REM_HND) || (r_req.cmd == CMD_REM_OWNER),
        "store written during sweep by a non-remove request")
    `ARCT_ASSERT_NXT(a_rem_hnd_once, i_clk, i_rst_n, rm_h, r_found && !rm_h,
        "remove by handle invalidated more than one entry")
    `ARCT_ASSERT_NXT(a_fin_result, i_clk, i_rst_n, fin_go, o_valid && (r_state == S_IDLE),
        "finished request did not present a result")
    `ARCT_ASSERT_IMP(a_clr_no_accept, i_clk, i_rst_n, r_state == S_CLR,
        o_stall && mem_we && !mem_wdata.valid,
        "clearing pass not invalidating or taking requests")

endmodule

`default_nettype wire

[dv/address_range_claim_table_core_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_range_claim_table_core_checker
// watches the request and result channels, keeps its own copy of the claim
// table, predicts every result and compares it field by field
// ----------------------------------------------------------------------------
`default_nettype none

module address_range_claim_table_core_checker (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [4:0]           i_cfg_wdata,
    input  wire                 i_valid,
    input  wire                 i_stall_in,
    input  wire arct_pkg::t_req i_req,
    input  wire                 i_rvalid,
    input  wire                 i_rstall,
    input  wire arct_pkg::t_rsp i_rsp,
    output int                  o_fail_count,
    output int                  o_pending
);
    import arct_pkg::*;

    localparam int N = ARCT_MAX_CLAIMS;

    logic        tbl_valid [N];
    logic [63:0] tbl_start [N];
    logic [4:0]  tbl_len [N];
    logic [15:0] tbl_owner [N];
    logic [63:0] tbl_detour [N];
    logic [31:0] tbl_handle [N];
    logic [31:0] next_hnd;
    logic [15:0] coll_seen;
    logic [4:0]  min_len;
    t_rsp        expected_rsp_q[$];

    function automatic bit spans_meet(logic [63:0] a, logic [5:0] alen,
                                      logic [63:0] b, logic [5:0] blen);
        if (a >= b) return (a - b) < {58'd0, blen};
        return (b - a) < {58'd0, alen};
    endfunction

    function automatic t_rsp apply_request(t_req r);
        t_rsp  o;
        bit    done;
        int    free_slot;
        logic [4:0] len;
        o = '0;
        o.status = ST_NOT_FOUND;
        done = 1'b0;
        free_slot = -1;
        case (r.cmd)
            CMD_INSTALL: begin
                if (r.target_addr == '0) begin
                    o.status = ST_TARGET_ZERO;
                end else if (r.detour_id == '0) begin
                    o.status = ST_DETOUR_ZERO;
                end else begin
                    for (int i = 0; i < N && !done; i++)
                        if (tbl_valid[i] && tbl_start[i] == r.target_addr &&
                            tbl_owner[i] == r.owner_id &&
                            tbl_detour[i] == r.detour_id) begin
                            o.status = ST_EXISTING;
                            o.handle_out = tbl_handle[i];
                            done = 1'b1;
                        end
                    len = r.measured_len;
                    if (len == '0) len = (min_len != '0) ? min_len : 5'd1;
                    for (int i = 0; i < N && !done; i++)
                        if (tbl_valid[i] && spans_meet(r.target_addr, {1'b0, len},
                                                       tbl_start[i], {1'b0, tbl_len[i]})) begin
                            o.status = ST_OVERLAP;
                            if (coll_seen != 16'hFFFF) coll_seen++;
                            done = 1'b1;
                        end
                    if (!done && r.patch_error != '0) begin
                        o.status = ST_BACKEND;
                        done = 1'b1;
                    end
                    if (!done) begin
                        for (int i = 0; i < N; i++)
                            if (!tbl_valid[i] && free_slot < 0) free_slot = i;
                        if (free_slot < 0) begin
                            o.status = ST_FULL;
                        end else begin
                            tbl_valid[free_slot] = 1'b1;
                            tbl_start[free_slot] = r.target_addr;
                            tbl_len[free_slot] = len;
                            tbl_owner[free_slot] = r.owner_id;
                            tbl_detour[free_slot] = r.detour_id;
                            tbl_handle[free_slot] = next_hnd;
                            o.handle_out = next_hnd;
                            next_hnd++;
                            if (next_hnd == '0) next_hnd = 32'd1;
                            o.status = ST_INSTALLED;
                        end
                    end
                end
            end
            CMD_REM_HND: begin
                if (r.handle != '0)
                    for (int i = 0; i < N && !done; i++)
                        if (tbl_valid[i] && tbl_handle[i] == r.handle) begin
                            tbl_valid[i] = 1'b0;
                            o.status = ST_REMOVED;
                            o.handle_out = r.handle;
                            done = 1'b1;
                        end
            end
            CMD_REM_OWNER: begin
                for (int i = 0; i < N; i++)
                    if (tbl_valid[i] && tbl_owner[i] == r.owner_id) begin
                        tbl_valid[i] = 1'b0;
                        if (o.removed_count < 7'd127) o.removed_count++;
                    end
                o.status = (o.removed_count != '0) ? ST_REMOVED : ST_NOT_FOUND;
            end
            CMD_FIND: begin
                o.status = ST_NOT_COVERED;
                for (int i = 0; i < N && !done; i++)
                    if (tbl_valid[i] && r.query_addr >= tbl_start[i] &&
                        (r.query_addr - tbl_start[i]) < {59'd0, tbl_len[i]}) begin
                        o.status = ST_COVERED;
                        o.handle_out = tbl_handle[i];
                        o.hit_owner = tbl_owner[i];
                        o.hit_target = tbl_start[i];
                        o.hit_len = tbl_len[i];
                        done = 1'b1;
                    end
            end
            CMD_CLR_COLL: begin
                coll_seen = '0;
                o.status = ST_REMOVED;
            end
            default: ;
        endcase
        o.collision_count = coll_seen;
        return o;
    endfunction

    task automatic report(string fld, logic [63:0] exp_v, logic [63:0] act_v);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("mismatch %s: expected %0h actual %0h", fld, exp_v, act_v);
    endtask

    always @(posedge i_clk) begin
        t_rsp e;
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) tbl_valid[i] = 1'b0;
            next_hnd = 32'd1;
            coll_seen = '0;
            min_len = MIN_LEN_RESET;
            expected_rsp_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) min_len = i_cfg_wdata;
            if (i_rvalid && !i_rstall) begin
                if (expected_rsp_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) $display("result with no request pending");
                end else begin
                    e = expected_rsp_q.pop_front();
                    if (e.status != i_rsp.status)
                        report("status", 64'(e.status), 64'(i_rsp.status));
                    if (e.handle_out != i_rsp.handle_out)
                        report("handle_out", 64'(e.handle_out), 64'(i_rsp.handle_out));
                    if (e.removed_count != i_rsp.removed_count)
                        report("removed_count", 64'(e.removed_count),
                               64'(i_rsp.removed_count));
                    if (e.hit_owner != i_rsp.hit_owner)
                        report("hit_owner", 64'(e.hit_owner), 64'(i_rsp.hit_owner));
                    if (e.hit_target != i_rsp.hit_target)
                        report("hit_target", e.hit_target, i_rsp.hit_target);
                    if (e.hit_len != i_rsp.hit_len)
                        report("hit_len", 64'(e.hit_len), 64'(i_rsp.hit_len));
                    if (e.collision_count != i_rsp.collision_count)
                        report("collision_count", 64'(e.collision_count),
                               64'(i_rsp.collision_count));
                end
            end
            if (i_valid && !i_stall_in)
                expected_rsp_q = {expected_rsp_q, apply_request(i_req)};
        end
        o_pending = expected_rsp_q.size();
    end

endmodule

`default_nettype wire

[dv/address_range_claim_table_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_range_claim_table_core_tb
// drives directed and random table commands with random gaps and result
// stalls, sweeps the minimum length register, and reports the verdict
// ----------------------------------------------------------------------------
`default_nettype none

module address_range_claim_table_core_tb;
    import arct_pkg::*;

    localparam int LAT = ARCT_MAX_CLAIMS + 3;
    localparam int WATCHDOG = 20000;
    localparam logic [2:0] CMD_BAD_LO = 3'd5;
    localparam logic [2:0] CMD_BAD_HI = 3'd7;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [4:0] cfg_wdata = '0;
    logic       req_valid = 1'b0;
    logic       req_stall;
    t_req       req = '0;
    logic       rsp_valid;
    logic       rsp_stall = 1'b0;
    t_rsp       rsp;
    int         fail_count;
    int         pending;
    int         idle_cycles = 0;
    int         rsp_wait = 0;
    logic       rsp_took = 1'b0;
    logic [31:0] handles_seen[$];
    logic [63:0] bases[8];
    logic [15:0] owners[4];

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    address_range_claim_table_core u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_valid(req_valid), .o_stall(req_stall), .i_req(req),
        .o_valid(rsp_valid), .i_stall(rsp_stall), .o_rsp(rsp)
    );

    address_range_claim_table_core_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_valid(req_valid), .i_stall_in(req_stall), .i_req(req),
        .i_rvalid(rsp_valid), .i_rstall(rsp_stall), .i_rsp(rsp),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge clk) begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // after each taken result a random stall is drawn and held against the next result
    always @(posedge clk) rsp_took <= rsp_valid && !rsp_stall;

    always @(negedge clk) begin
        int w;
        w = rsp_took ? int'($urandom_range(0, 16)) : rsp_wait;
        rsp_stall <= (w != 0);
        rsp_wait <= (rsp_valid && w != 0) ? w - 1 : w;
    end

    task automatic send(t_req r, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 16);
        @(negedge clk);
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (LAT) @(negedge clk);
    endtask

    task automatic write_min_len(logic [4:0] v);
        drain();
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic t_req rand_fields();
        t_req r;
        logic [255:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom};
        r = raw[$bits(t_req)-1:0];
        return r;
    endfunction

    function automatic t_req mk(logic [2:0] c, logic [15:0] o, logic [63:0] t,
                                logic [63:0] d, logic [4:0] l, logic [2:0] e);
        t_req r;
        r = rand_fields();
        r.cmd = c; r.owner_id = o; r.target_addr = t; r.detour_id = d;
        r.measured_len = l; r.patch_error = e;
        return r;
    endfunction

    function automatic t_req rand_cmd();
        t_req r;
        int k;
        r = rand_fields();
        k = $urandom_range(0, 99);
        r.owner_id = owners[$urandom_range(0, 3)];
        if (k < 45) begin
            r.cmd = CMD_INSTALL;
            r.target_addr = bases[$urandom_range(0, 7)] + 64'($urandom_range(0, 300));
            if ($urandom_range(0, 30) == 0) r.target_addr = '0;
            r.detour_id = ($urandom_range(0, 30) == 0) ? 64'd0 : {60'd0, 4'($urandom)};
            if ($urandom_range(0, 3) == 0) r.measured_len = '0;
            if ($urandom_range(0, 3) != 0) r.patch_error = '0;
        end else if (k < 60) begin
            r.cmd = CMD_REM_HND;
            if (handles_seen.size() != 0 && $urandom_range(0, 3) != 0)
                r.handle = handles_seen[$urandom_range(0, handles_seen.size() - 1)];
            else if ($urandom_range(0, 1) == 1) r.handle = '0;
        end else if (k < 66) begin
            r.cmd = CMD_REM_OWNER;
        end else if (k < 92) begin
            r.cmd = CMD_FIND;
            r.query_addr = bases[$urandom_range(0, 7)] + 64'($urandom_range(0, 340));
        end else if (k < 95) begin
            r.cmd = CMD_CLR_COLL;
        end else begin
            r.cmd = 3'($urandom_range(int'(CMD_BAD_LO), int'(CMD_BAD_HI)));
        end
        return r;
    endfunction

    always @(posedge clk)
        if (rsp_valid && !rsp_stall && rsp.status == ST_INSTALLED)
            handles_seen = {handles_seen, rsp.handle_out};

    initial begin
        t_req r;
        logic [4:0] min_len_seq[4];
        bases = '{64'h1000, 64'h0000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FEC0,
                  64'h8000_0000_0000_0000, 64'h0000_1234_5678_0000, 64'h40,
                  64'h7FFF_FFFF_FFFF_FF00, 64'h0000_0000_FFFF_0000};
        owners = '{16'h0000, 16'hFFFF, 16'h1234, 16'h0042};
        min_len_seq = '{5'd0, 5'd31, 5'd1, 5'd12};
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // directed part
        send(mk(CMD_INSTALL, 16'h1, 64'd0, 64'd7, 5'd4, 3'd0), 1'b0);
        send(mk(CMD_INSTALL, 16'h1, 64'h10, 64'd0, 5'd4, 3'd0), 1'b0);
        send(mk(CMD_INSTALL, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                5'd31, 3'd0), 1'b0);
        send(mk(CMD_INSTALL, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                5'd31, 3'd7), 1'b0);
        send(mk(CMD_INSTALL, 16'h2, 64'hFFFF_FFFF_FFFF_FFF0, 64'd3, 5'd31, 3'd0), 1'b0);
        send(mk(CMD_INSTALL, 16'h3, 64'h1, 64'd3, 5'd0, 3'd0), 1'b0);
        send(mk(CMD_INSTALL, 16'h3, 64'h6, 64'd3, 5'd1, 3'd0), 1'b0);
        send(mk(CMD_INSTALL, 16'h3, 64'h5, 64'd3, 5'd1, 3'd0), 1'b0);
        send(mk(CMD_INSTALL, 16'h3, 64'h100, 64'd3, 5'd2, 3'd4), 1'b0);
        r = mk(CMD_FIND, '0, '0, '0, '0, '0); r.query_addr = 64'hFFFF_FFFF_FFFF_FFFF;
        send(r, 1'b0);
        r.query_addr = 64'h5; send(r, 1'b0);
        r.query_addr = 64'h0; send(r, 1'b0);
        r = mk(CMD_REM_HND, '0, '0, '0, '0, '0); r.handle = 32'd1; send(r, 1'b0);
        r.handle = 32'd1; send(r, 1'b0);
        r.handle = 32'd0; send(r, 1'b0);
        r.handle = 32'hFFFF_FFFF; send(r, 1'b0);
        send(mk(CMD_CLR_COLL, '0, '0, '0, '0, '0), 1'b0);
        send(mk(CMD_REM_OWNER, 16'h3, '0, '0, '0, '0), 1'b0);
        send(mk(CMD_REM_OWNER, 16'h3, '0, '0, '0, '0), 1'b0);
        send(mk(CMD_BAD_LO, '0, '0, '0, '0, '0), 1'b0);
        send(mk(CMD_BAD_HI, '0, '0, '0, '0, '0), 1'b0);
        // fill the table to full
        for (int i = 0; i < ARCT_MAX_CLAIMS + 1; i++)
            send(mk(CMD_INSTALL, 16'h9, 64'h1_0000 + 64'(i) * 64'd64, 64'd1, 5'd8, 3'd0),
                 $urandom_range(0, 1) == 1);
        drain();
        send(mk(CMD_REM_OWNER, 16'h9, '0, '0, '0, '0), 1'b0);
        send(mk(CMD_REM_OWNER, 16'h2, '0, '0, '0, '0), 1'b0);
        send(mk(CMD_REM_OWNER, 16'hFFFF, '0, '0, '0, '0), 1'b0);

        // random part over several register settings
        for (int ph = 0; ph < 4; ph++) begin
            write_min_len(min_len_seq[ph]);
            for (int n = 0; n < 90; n++) begin
                send(rand_cmd(), $urandom_range(0, 4) == 0);
                if (ph == 1 && n == 50) drain();
            end
        end
        write_min_len(MIN_LEN_RESET);
        for (int n = 0; n < 10; n++) send(rand_cmd(), 1'b0);
        drain();

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
